FILE: sv/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, constants and the segment table of the two-digit lcd writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

    localparam int NUM_POSITIONS = 6;
    localparam int NUM_ROWS      = 4;
    localparam int ROW_STRIDE    = 5;

    localparam int PAIRS      = (NUM_POSITIONS + 1) / 2;
    localparam int STORE_SIZE = NUM_ROWS * PAIRS;

    localparam int NUMBER_W = 31;
    localparam int POS_W    = 3;
    localparam int CPOS_W   = POS_W + 1;
    localparam int DIG_W    = 4;
    localparam int REM_W    = 7;
    localparam int OFF_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int SEG_W    = 16;
    localparam int NIB_W    = 4;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W    = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int PAIR_W   = CPOS_W - 1;

    // floor(n / 100) = (n * RECIP) >> RECIP_SHIFT, exact for n < 2**31
    localparam int PROD_W      = 2 * NUMBER_W;
    localparam int RECIP_SHIFT = 37;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam logic [NUMBER_W-1:0] RECIP = 31'd1374389535;
    localparam logic [REM_W-1:0]    HUNDRED = 7'd100;
    localparam logic [DIG_W-1:0]    TEN     = 4'd10;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [NIB_W-1:0] LOW_MASK  = 4'hF;

    typedef struct packed {
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] units;
        logic [POS_W-1:0] pos;
    } cmd_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIG_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        begin
            unique case (digit)
                4'd0:    pat = 16'h1551;
                4'd1:    pat = 16'h0110;
                4'd2:    pat = 16'h1E11;
                4'd3:    pat = 16'h1B11;
                4'd4:    pat = 16'h0B50;
                4'd5:    pat = 16'h1B41;
                4'd6:    pat = 16'h1F41;
                4'd7:    pat = 16'h0111;
                4'd8:    pat = 16'h1F51;
                4'd9:    pat = 16'h1B51;
                default: pat = '0;
            endcase
            return pat;
        end
    endfunction

    // tens digit of a value below 100, by parallel threshold compares
    function automatic logic [DIG_W-1:0] tens_of(input logic [REM_W-1:0] r);
        logic [DIG_W-1:0] t;
        begin
            t = '0;
            for (int i = 1; i < 10; i++) begin
                if (r >= REM_W'(i * 10)) begin
                    t = DIG_W'(i);
                end
            end
            return t;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts items, splits the number into tens and units and drops items
// whose start position lies off the display.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_front
    import lcdw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [NUMBER_W-1:0] number,
    input  wire logic [POS_W-1:0]    position,
    output logic                     push,
    output cmd_t                     push_cmd,
    input  wire logic                q_full
);

    logic                s1_valid_reg, s1_valid_next;
    logic [NUMBER_W-1:0] s1_num_reg;
    logic [POS_W-1:0]    s1_pos_reg;

    logic                s2_valid_reg, s2_valid_next;
    logic [QUO_W-1:0]    s2_quo_reg;
    logic [REM_W-1:0]    s2_low_reg;
    logic [POS_W-1:0]    s2_pos_reg;

    logic                s3_valid_reg, s3_valid_next;
    logic [REM_W-1:0]    s3_rem_reg;
    logic [POS_W-1:0]    s3_pos_reg;

    logic              s1_ready, s2_ready, s3_ready;
    logic              s3_drop, s3_leave;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  rem;
    logic [DIG_W-1:0]  tens;

    assign s3_drop  = (CPOS_W'(s3_pos_reg) >= CPOS_W'(NUM_POSITIONS));
    assign s3_leave = s3_valid_reg && (s3_drop || !q_full);
    assign s3_ready = !s3_valid_reg || s3_leave;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    assign prod = PROD_W'(s1_num_reg) * PROD_W'(RECIP);
    assign rem  = s2_low_reg - REM_W'(REM_W'(s2_quo_reg) * HUNDRED);
    assign tens = tens_of(s3_rem_reg);

    assign push           = s3_valid_reg && !s3_drop && !q_full;
    assign push_cmd.tens  = tens;
    assign push_cmd.units = DIG_W'(s3_rem_reg - REM_W'(tens * TEN));
    assign push_cmd.pos   = s3_pos_reg;

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_num_reg <= number;
            s1_pos_reg <= position;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_quo_reg <= prod[RECIP_SHIFT +: QUO_W];
            s2_low_reg <= s1_num_reg[REM_W-1:0];
            s2_pos_reg <= s1_pos_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_rem_reg <= rem;
            s3_pos_reg <= s2_pos_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lcdw_queue.sv
// ----------------------------------------------------------------------------
// lcdw_queue
// Short first-in first-out queue of digit commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_queue
    import lcdw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t             entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == Q_CW'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back
// Walks the rows of each digit, merges segment nibbles into the display
// store and issues one register write per cycle while out_stall allows it.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_back
    import lcdw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_not_empty,
    input  cmd_t                  cmd,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [OFF_W-1:0]      reg_offset,
    output logic [BYTE_W-1:0]     reg_value,
    output logic                  last
);

    logic [BYTE_W-1:0] store_reg [STORE_SIZE];
    logic              dig_reg, dig_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              out_valid_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [BYTE_W-1:0] value_reg;
    logic              last_reg;

    logic              fire, row_end, units_on, is_last;
    logic [DIG_W-1:0]  digit;
    logic [CPOS_W-1:0] cur_pos, units_pos;
    logic [PAIR_W-1:0] pair;
    logic [IDX_W-1:0]  idx;
    logic [SEG_W-1:0]  pattern;
    logic [NIB_W-1:0]  nib;
    logic [BYTE_W-1:0] old_byte, new_byte;
    logic [OFF_W-1:0]  offset;

    assign fire      = q_not_empty && (!out_valid_reg || !out_stall);
    assign units_pos = CPOS_W'(cmd.pos) + 1'b1;
    assign units_on  = (units_pos < CPOS_W'(NUM_POSITIONS));
    assign row_end   = (row_reg == ROW_W'(NUM_ROWS - 1));
    assign is_last   = row_end && (dig_reg || !units_on);
    assign pop       = fire && is_last;

    assign digit    = dig_reg ? cmd.units : cmd.tens;
    assign cur_pos  = dig_reg ? units_pos : CPOS_W'(cmd.pos);
    assign pair     = cur_pos[CPOS_W-1:1];
    assign idx      = IDX_W'(IDX_W'(row_reg) * IDX_W'(PAIRS) + IDX_W'(pair));
    assign pattern  = seg_pattern(digit);
    assign nib      = pattern[row_reg * NIB_W +: NIB_W];
    assign old_byte = (idx < IDX_W'(STORE_SIZE)) ? store_reg[idx] : '0;
    assign offset   = OFF_W'(OFF_W'(row_reg) * OFF_W'(ROW_STRIDE) + OFF_W'(pair));

    // odd position owns the high nibble
    always_comb
    begin
        if (cur_pos[0])
        begin
            new_byte = {nib, old_byte[NIB_W-1:0]};
        end
        else
        begin
            new_byte = {old_byte[BYTE_W-1:NIB_W], nib};
        end
    end

    always_comb
    begin
        dig_next = dig_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (is_last)
            begin
                dig_next = 1'b0;
                row_next = '0;
            end
            else if (row_end)
            begin
                dig_next = 1'b1;
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg       <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_SIZE; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            dig_reg <= dig_next;
            row_reg <= row_next;
            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                store_reg[idx] <= new_byte;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            offset_reg <= offset;
            value_reg  <= new_byte;
            last_reg   <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_offset = offset_reg;
    assign reg_value  = value_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

FILE: sv/lcd_two_digit_segment_writer.sv
// ----------------------------------------------------------------------------
// lcd_two_digit_segment_writer
// Shows the last two decimal digits of a number on a segment lcd.
// ----------------------------------------------------------------------------
// Each item carries a number and the position of its tens digit. The block
// writes the tens and units segment patterns into its shadow of the display
// registers and emits every updated byte as one write, offset and full value,
// with last set on the final write of the item; an item whose start position
// is off the display produces no writes. A three-stage front (input register,
// reciprocal multiply for the hundreds quotient, remainder and digit split)
// feeds a two-entry command queue; the back issues one write per cycle when
// out_stall lets it, so an item with both digits on the display gives eight
// writes, one with only the tens digit four; a skipped item is dropped in the
// last front stage. The single read-modify-write port of the display shadow
// sets the write rate. An item passes the front registers and the queue before
// its first write is registered on the outputs; the shadow is all zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_two_digit_segment_writer
    import lcdw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [NUMBER_W-1:0] number,
    input  wire logic [POS_W-1:0]    position,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [OFF_W-1:0]         reg_offset,
    output logic [BYTE_W-1:0]        reg_value,
    output logic                     last
);

    logic push, q_full, pop, q_not_empty;
    cmd_t push_cmd, head;

    lcdw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .number   (number),
        .position (position),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    lcdw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    lcdw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .cmd         (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reg_offset  (reg_offset),
        .reg_value   (reg_value),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: bench/lcd_two_digit_segment_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_two_digit_segment_writer_tb
// Self-checking bench for the two-digit segment lcd writer.
// ----------------------------------------------------------------------------
// A short table of hand-picked items runs first, a few with their writes typed
// in by hand, the others checked against a local model of the display shadow.
// Random items follow in bursts with random gaps. The receiver stalls on its
// own pattern and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module lcd_two_digit_segment_writer_tb
    import lcdw_pkg::*;
;

    localparam int N_DIRECTED = 18;
    localparam int N_RANDOM   = 452;

    // segment codes, digit 9 first and digit 0 last
    localparam logic [9:0][15:0] SEG_CODES = {
        16'h1B51, 16'h1F51, 16'h0111, 16'h1F41, 16'h1B41,
        16'h0B50, 16'h1B11, 16'h1E11, 16'h0110, 16'h1551
    };

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] value;
        logic              last;
    } lcd_write_t;

    // hand_count writes with values packed first-write-first in hand_vals
    typedef struct packed {
        logic [NUMBER_W-1:0] num;
        logic [POS_W-1:0]    pos;
        logic                hand;
        logic [3:0]          hand_count;
        logic [63:0]         hand_vals;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [NUMBER_W-1:0] number;
    logic [POS_W-1:0]    position;
    logic                out_valid;
    logic                out_stall;
    logic [OFF_W-1:0]    reg_offset;
    logic [BYTE_W-1:0]   reg_value;
    logic                last;

    lcd_write_t  pending_writes [$];
    lcd_write_t  item_writes [8];
    int          item_count;
    logic [7:0]  shadow_bytes [STORE_SIZE];
    stim_row_t   directed_rows [N_DIRECTED];
    lcd_write_t  want;
    int          failures;
    int          accepted_items;
    int          burst_left;

    lcd_two_digit_segment_writer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_offset (reg_offset),
        .reg_value  (reg_value),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #4_000_000;
        $display("lcd_two_digit_segment_writer regression: fail");
        $finish;
    end

    // updates the shadow and works out the writes one item causes
    task automatic compute_segment_writes(input logic [NUMBER_W-1:0] n,
                                          input logic [POS_W-1:0] p);
        int         digit [2];
        int         pos;
        int         idx;
        logic [3:0] nib;
        logic [15:0] pattern;
        digit[0] = (n % 100) / 10;
        digit[1] = n % 10;
        item_count = 0;
        for (int d = 0; d < 2; d++)
        begin
            pos = p + d;
            if (pos < NUM_POSITIONS)
            begin
                pattern = SEG_CODES[digit[d]];
                for (int row = 0; row < NUM_ROWS; row++)
                begin
                    idx = row * PAIRS + pos / 2;
                    nib = pattern[4*row +: 4];
                    if (pos % 2 == 1)
                        shadow_bytes[idx][7:4] = nib;
                    else
                        shadow_bytes[idx][3:0] = nib;
                    item_writes[item_count].offset = OFF_W'(row * ROW_STRIDE + pos / 2);
                    item_writes[item_count].value  = shadow_bytes[idx];
                    item_writes[item_count].last   = 1'b0;
                    item_count++;
                end
            end
        end
        if (item_count > 0)
            item_writes[item_count-1].last = 1'b1;
    endtask

    // offers one item, with a random gap when a burst runs out
    task automatic send_item(input logic [NUMBER_W-1:0] n, input logic [POS_W-1:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                number   <= NUMBER_W'($urandom);
                position <= POS_W'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        number   <= n;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accepted_items++;
    endtask

    initial
    begin : receiver
        int  mode_left;
        int  stall_pct;
        bit  hold_done;
        mode_left = 0;
        stall_pct = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && accepted_items >= 120)
            begin
                // long hold-off so the block fills and pushes back on its input
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(8, 60);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                mode_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write offset %0d value %02h last %0b",
                         $realtime, reg_offset, reg_value, last);
                failures++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (reg_offset !== want.offset)
                begin
                    $display("%0t: reg_offset expected %0d got %0d",
                             $realtime, want.offset, reg_offset);
                    failures++;
                end
                if (reg_value !== want.value)
                begin
                    $display("%0t: reg_value expected %02h got %02h",
                             $realtime, want.value, reg_value);
                    failures++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b got %0b", $realtime, want.last, last);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        logic [NUMBER_W-1:0] n;
        logic [POS_W-1:0]    p;
        lcd_write_t          w;
        int                  sel;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        number         = '0;
        position       = '0;
        failures       = 0;
        accepted_items = 0;
        burst_left     = 0;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;

        directed_rows = '{
            // from a cleared shadow: zero at the left edge, both nibbles of one byte
            '{31'd0,          3'd0, 1'b1, 4'd8, 64'h01050501_11555511},
            // start off the display: no writes
            '{31'd99,         3'd6, 1'b1, 4'd0, 64'h0},
            '{31'd7,          3'd7, 1'b1, 4'd0, 64'h0},
            // largest number ends in 47
            '{31'h7FFFFFFF,   3'd4, 1'b1, 4'd8, 64'h00050B00_10151B00},
            // last position: only the tens digit lands
            '{31'd95,         3'd5, 1'b1, 4'd4, 64'h1055BB10_00000000},
            '{31'd12,         3'd1, 1'b0, 4'd0, 64'h0},
            '{31'd34,         3'd2, 1'b0, 4'd0, 64'h0},
            '{31'd56,         3'd3, 1'b0, 4'd0, 64'h0},
            '{31'd78,         3'd0, 1'b0, 4'd0, 64'h0},
            // same item again, bytes do not change but are still written
            '{31'd78,         3'd0, 1'b0, 4'd0, 64'h0},
            '{31'd90,         3'd1, 1'b0, 4'd0, 64'h0},
            '{31'd100,        3'd2, 1'b0, 4'd0, 64'h0},
            '{31'd1234567,    3'd3, 1'b0, 4'd0, 64'h0},
            '{31'd5,          3'd4, 1'b0, 4'd0, 64'h0},
            '{31'd2147483600, 3'd5, 1'b0, 4'd0, 64'h0},
            '{31'h55555555,   3'd0, 1'b0, 4'd0, 64'h0},
            '{31'h2AAAAAAA,   3'd2, 1'b0, 4'd0, 64'h0},
            '{31'h7FFFFFFF,   3'd7, 1'b0, 4'd0, 64'h0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_item(directed_rows[r].num, directed_rows[r].pos);
            compute_segment_writes(directed_rows[r].num, directed_rows[r].pos);
            if (directed_rows[r].hand)
            begin
                for (int k = 0; k < directed_rows[r].hand_count; k++)
                begin
                    w.offset = item_writes[k].offset;
                    w.value  = directed_rows[r].hand_vals[63-8*k -: 8];
                    w.last   = (k == directed_rows[r].hand_count - 1);
                    pending_writes.push_back(w);
                end
            end
            else
            begin
                for (int k = 0; k < item_count; k++)
                    pending_writes.push_back(item_writes[k]);
            end
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                n = NUMBER_W'($urandom_range(0, 99));
            else if (sel < 8)
                n = NUMBER_W'($urandom);
            else
                n = NUMBER_W'($urandom_range(0, 99) + 100 * $urandom_range(0, 21474835));
            if ($urandom_range(0, 9) < 9)
                p = POS_W'($urandom_range(0, 5));
            else
                p = POS_W'($urandom_range(6, 7));
            send_item(n, p);
            compute_segment_writes(n, p);
            for (int k = 0; k < item_count; k++)
                pending_writes.push_back(item_writes[k]);
        end

        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        // catch any stray write after the last one
        repeat (40) @(posedge clk);

        if (failures == 0)
            $display("lcd_two_digit_segment_writer regression: pass");
        else
            $display("lcd_two_digit_segment_writer regression: fail");
        $finish;
    end

endmodule
